### sv/trc_pkg.sv
// Shared types and constants for the text cell row renderer.
package trc_pkg;

    localparam int TEXT_COLUMNS = 80;
    localparam int GLYPH_HEIGHT = 16;
    localparam int CELL_WIDTH   = 8;
    localparam int GLYPH_COUNT  = 256;
    localparam int GLYPH_ROWS   = 16;
    localparam int STORE_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int STORE_AW     = $clog2(STORE_DEPTH);
    localparam int PALETTE_DEPTH = 16;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [1:0] KIND_FONT    = 2'd0;
    localparam logic [1:0] KIND_PALETTE = 2'd1;
    localparam logic [1:0] KIND_DRAW    = 2'd2;

    localparam logic       ADDR_COLOUR_DEPTH = 1'b0;
    localparam logic [31:0] MASK_16BIT = 32'h0000_ffff;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [3:0]  font_row;
        logic [6:0]  cell_column;
        logic [3:0]  palette_index;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] pixel_colour;
        logic [9:0]  pixel_x;
        logic        last;
    } pix_t;

    // One resolved cell row: glyph bits and the two colours, already masked.
    typedef struct packed {
        logic [7:0]  glyph_bits;
        logic [31:0] set_colour;
        logic [31:0] clear_colour;
        logic [6:0]  cell_column;
    } draw_t;

endpackage

### sv/text_cell_row_renderer_core.sv
// Top level of the text cell row renderer: configuration register and the three stages.
//
// Requests arrive on req_valid/req_ready with one req_t. A font write stores one
// glyph row byte, a palette write stores one 32-bit colour; neither gives output.
// A draw request produces eight pix_t results on pix_valid/pix_ready, leftmost
// pixel first, with last set on the eighth. Draws beyond the screen width give
// nothing; rows beyond the glyph height draw in the clear-bit colour.
// The first pixel of a draw passes the lookup registers, a queue entry and the
// serializer before the output register presents it on pix. A new request is taken
// every cycle while the queue has room; the back end emits one pixel per cycle while
// the receiver takes them, so a stream of draws is paced by the single pixel serializer.
// When the receiver stalls, the output register holds its pixel, the serializer
// and queue fill, and req_ready drops once the front lookup stage is blocked.
// Reset empties all pipeline stages and sets colour_depth to 16-bit pixels; the
// font and palette stores are not cleared and must be written before use. colour_depth
// is written over the APB port at address 0; the user must write it only while idle; the block does not enforce it.
module text_cell_row_renderer_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          req_valid,
    output logic          req_ready,
    input  trc_pkg::req_t req,
    output logic          pix_valid,
    input  logic          pix_ready,
    output trc_pkg::pix_t pix
);

    logic colour_depth_reg;
    logic colour_depth_next;
    logic cfg_write;

    logic           fq_valid;
    logic           fq_ready;
    trc_pkg::draw_t fq_data;
    logic           qb_valid;
    logic           qb_ready;
    trc_pkg::draw_t qb_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == trc_pkg::ADDR_COLOUR_DEPTH);
    assign colour_depth_next = cfg_write ? pwdata[0] : colour_depth_reg;
    assign prdata = (paddr[2] == trc_pkg::ADDR_COLOUR_DEPTH)
                    ? {31'b0, colour_depth_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colour_depth_reg <= 1'b0;
        end
        else
        begin
            colour_depth_reg <= colour_depth_next;
        end
    end

    trc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .colour_depth (colour_depth_reg),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req          (req),
        .q_valid      (fq_valid),
        .q_ready      (fq_ready),
        .q_data       (fq_data)
    );

    trc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    trc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_data    (qb_data),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix)
    );

    // In 16-bit mode the upper colour half must never reach the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !colour_depth_reg |-> pix.pixel_colour[31:16] == 16'h0000)
        else $error("upper colour bits set in 16-bit mode");

    // The last mark and the pixel position within the cell must agree.
    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid |-> pix.last == (pix.pixel_x[2:0] == 3'(trc_pkg::CELL_WIDTH - 1)))
        else $error("last mark out of step with pixel position");

endmodule

### sv/trc_front.sv
// Front end: accepts requests, applies font and palette writes, looks up draw data.
module trc_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          colour_depth,
    input  logic          req_valid,
    output logic          req_ready,
    input  trc_pkg::req_t req,
    output logic          q_valid,
    input  logic          q_ready,
    output trc_pkg::draw_t q_data
);

    logic [7:0]  glyph_mem [trc_pkg::STORE_DEPTH];
    logic [31:0] palette_mem [trc_pkg::PALETTE_DEPTH];

    logic [7:0]  glyph_rd_reg;
    logic [31:0] set_rd_reg;
    logic [31:0] clear_rd_reg;
    logic [6:0]  column_reg;
    logic        row_ok_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;

    logic                          accept;
    logic                          row_ok;
    logic                          column_ok;
    logic                          font_we;
    logic                          palette_we;
    logic                          draw_rd;
    logic [trc_pkg::STORE_AW-1:0]  glyph_addr;
    logic [31:0]                   colour_mask;

    assign req_ready  = !s1_valid_reg || q_ready;
    assign accept     = req_valid && req_ready;
    assign glyph_addr = {req.char_code, req.font_row};
    assign row_ok     = {1'b0, req.font_row} < 5'(trc_pkg::GLYPH_HEIGHT);
    assign column_ok  = {1'b0, req.cell_column} < 8'(trc_pkg::TEXT_COLUMNS);
    assign font_we    = accept && (req.kind == trc_pkg::KIND_FONT) && row_ok;
    assign palette_we = accept && (req.kind == trc_pkg::KIND_PALETTE);
    assign draw_rd    = accept && (req.kind == trc_pkg::KIND_DRAW) && column_ok;

    // Writes and reads happen in request order, so a draw always sees earlier writes.
    always_ff @(posedge clk)
    begin
        if (font_we)
        begin
            glyph_mem[glyph_addr] <= req.write_data[7:0];
        end
        if (draw_rd)
        begin
            glyph_rd_reg <= glyph_mem[glyph_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (palette_we)
        begin
            palette_mem[req.palette_index] <= req.write_data;
        end
        if (draw_rd)
        begin
            clear_rd_reg <= palette_mem[req.attribute[3:0]];
            set_rd_reg   <= palette_mem[req.attribute[7:4]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw_rd)
        begin
            column_reg <= req.cell_column;
            row_ok_reg <= row_ok;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = draw_rd;
        end
        else if (q_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    assign colour_mask = colour_depth ? 32'hffff_ffff : trc_pkg::MASK_16BIT;

    assign q_valid             = s1_valid_reg;
    assign q_data.glyph_bits   = row_ok_reg ? glyph_rd_reg : 8'h00;
    assign q_data.set_colour   = set_rd_reg & colour_mask;
    assign q_data.clear_colour = clear_rd_reg & colour_mask;
    assign q_data.cell_column  = column_reg;

    // A held lookup must not be overwritten by a new request.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !q_ready |=> s1_valid_reg && $stable(column_reg)
            && $stable(glyph_rd_reg))
        else $error("front lookup changed while stalled");

endmodule

### sv/trc_queue.sv
// Short queue of resolved cell rows between the front and back ends.
module trc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  trc_pkg::draw_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output trc_pkg::draw_t pop_data
);

    localparam int PW = (trc_pkg::QUEUE_DEPTH > 1) ? $clog2(trc_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(trc_pkg::QUEUE_DEPTH + 1);

    trc_pkg::draw_t entry_reg [trc_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           push;
    logic           pop;

    assign push_ready = count_reg != CW'(trc_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(trc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(trc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(trc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

### sv/trc_back.sv
// Back end: serializes one cell row into eight pixels through an output register.
module trc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  trc_pkg::draw_t q_data,
    output logic           pix_valid,
    input  logic           pix_ready,
    output trc_pkg::pix_t  pix
);

    logic        active_reg;
    logic        active_next;
    logic [7:0]  bits_reg;
    logic [7:0]  bits_next;
    logic [31:0] set_reg;
    logic [31:0] set_next;
    logic [31:0] clear_reg;
    logic [31:0] clear_next;
    logic [6:0]  column_reg;
    logic [6:0]  column_next;
    logic [2:0]  cnt_reg;
    logic [2:0]  cnt_next;
    logic        pix_valid_reg;
    logic        pix_valid_next;
    trc_pkg::pix_t pix_reg;
    trc_pkg::pix_t pix_next;

    logic out_free;
    logic emit;
    logic last_emit;
    logic load;

    assign out_free  = !pix_valid_reg || pix_ready;
    assign emit      = active_reg && out_free;
    assign last_emit = emit && (cnt_reg == 3'(trc_pkg::CELL_WIDTH - 1));
    // The next cell row is taken as the last pixel of the current one goes out.
    assign q_ready   = !active_reg || last_emit;
    assign load      = q_valid && q_ready;

    always_comb
    begin
        active_next = active_reg;
        bits_next   = bits_reg;
        set_next    = set_reg;
        clear_next  = clear_reg;
        column_next = column_reg;
        cnt_next    = cnt_reg;
        if (load)
        begin
            active_next = 1'b1;
            bits_next   = q_data.glyph_bits;
            set_next    = q_data.set_colour;
            clear_next  = q_data.clear_colour;
            column_next = q_data.cell_column;
            cnt_next    = '0;
        end
        else if (emit)
        begin
            active_next = !last_emit;
            bits_next   = {bits_reg[6:0], 1'b0};
            cnt_next    = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        pix_next       = pix_reg;
        if (emit)
        begin
            pix_valid_next        = 1'b1;
            pix_next.pixel_colour = bits_reg[7] ? set_reg : clear_reg;
            pix_next.pixel_x      = {column_reg, cnt_reg};
            pix_next.last         = cnt_reg == 3'(trc_pkg::CELL_WIDTH - 1);
        end
        else if (pix_ready)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg   <= bits_next;
        set_reg    <= set_next;
        clear_reg  <= clear_next;
        column_reg <= column_next;
        cnt_reg    <= cnt_next;
        pix_reg    <= pix_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    assign pix_valid = pix_valid_reg;
    assign pix       = pix_reg;

endmodule
